// File: src/hsl2rgba_pkg.sv
// Shared constants and types for the HSL to packed RGBA pixel converter.
// Depends on nothing; imported by the converter top level.
`timescale 1ns / 1ps

package hsl2rgba_pkg;

  // Default number of fraction bits in the internal fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Saturation and lightness are given in tenths of a percent.
  localparam int PCT_MAX = 1000;
  // 1000 = 8 * 125; the factor of 8 is absorbed into the fixed-point shift.
  localparam int PCT_DIV = PCT_MAX / 8;
  localparam int PCT_RND = PCT_DIV / 2;

  // Hue is given in tenths of a degree.
  localparam int HUE_FULL = 3600;
  // Bias that makes every 16-bit signed hue positive without changing it mod 3600.
  localparam int HUE_BIAS = HUE_FULL * 10;
  localparam int HUE_STEPS = 5;

  // Width of one sixty-degree sector in tenths of a degree.
  localparam int SECTOR_SPAN = 600;
  localparam int X_DIV = SECTOR_SPAN / 8;
  localparam int X_RND = SECTOR_SPAN / 2;

  localparam int BYTE_MAX = 255;

  // Sixty-degree hue sectors, named by the colors at their two ends.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

// File: src/hsl_to_rgba_pixel_converter_unit.sv
// HSL to packed RGBA pixel converter: nine-stage pipeline, one pixel per request.
// Depends on hsl2rgba_pkg for constants and the hue sector type.
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// in_      in   in_valid/in_stall  hue_tenths[15:0] signed, sat_tenths[11:0],
//                                  light_tenths[11:0], alpha_byte[7:0]
// out_     out  out_valid/out_stall rgba_word[31:0] = {A, B, G, R}
//
// One request enters per clock while in_stall is low; a result passes through
// the nine register stages of the datapath before it leaves.
// Reset (rst_n low at a clock edge) empties every stage.
// A stall on the output holds only the stages that are full behind it, so
// bubbles are squeezed out and requests still enter until every stage is full.

module hsl_to_rgba_pixel_converter_unit #(
  parameter int FRAC_BITS = hsl2rgba_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_hue_tenths,
  input  logic        [11:0] in_sat_tenths,
  input  logic        [11:0] in_light_tenths,
  input  logic        [7:0]  in_alpha_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [31:0] out_rgba_word
);

  import hsl2rgba_pkg::*;

  localparam int NSTG   = 9;
  localparam int ONE_W  = FRAC_BITS + 1;
  localparam logic [ONE_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ONE_W-1:0] HALF = ONE >> 1;

  // Percent scaling: floor((p * 2^(F-3) + PCT_RND) / PCT_DIV) by reciprocal.
  localparam int PCT_NW = FRAC_BITS + 7;
  localparam int PCT_SH = FRAC_BITS + 8;
  localparam int PCT_KW = FRAC_BITS + 2;
  localparam int PCT_QW = ONE_W + 7;
  localparam logic [PCT_KW-1:0] PCT_K = PCT_KW'((64'd1 << PCT_SH) / PCT_DIV);

  // Intermediate value: floor(floor((C * w + X_RND) / 8) / X_DIV) by reciprocal.
  localparam int XP_W = ONE_W + 10;
  localparam int X_NW = FRAC_BITS + 8;
  localparam int X_SH = FRAC_BITS + 9;
  localparam int X_KW = FRAC_BITS + 3;
  localparam logic [X_KW-1:0] X_K = X_KW'((64'd1 << X_SH) / X_DIV);

  localparam int CP_W = 2 * ONE_W;
  localparam int BP_W = ONE_W + 9;

  // Pipeline control.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = {vld_r[NSTG-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NSTG-1];

  function automatic logic [7:0] to_byte(input logic [ONE_W-1:0] comp,
                                         input logic [ONE_W-1:0] offs);
    logic [ONE_W:0]   v;
    logic [ONE_W-1:0] vc;
    logic [BP_W-1:0]  p;
    logic [8:0]       q;
    v  = {1'b0, comp} + {1'b0, offs};
    vc = (v > {1'b0, ONE}) ? ONE : v[ONE_W-1:0];
    p  = {vc, 8'd0} - BP_W'(vc) + BP_W'(HALF);
    q  = p[FRAC_BITS +: 9];
    return (q > 9'(BYTE_MAX)) ? 8'(BYTE_MAX) : q[7:0];
  endfunction

  // Stage 0: bias the hue positive, clamp and pre-scale saturation and lightness.
  logic [17:0]       hsum;
  logic [9:0]        sat_c;
  logic [9:0]        light_c;
  logic [16:0]       st0_hoff_r;
  logic [16:0]       st0_hoff_nxt;
  logic [PCT_NW-1:0] st0_sn_r;
  logic [PCT_NW-1:0] st0_sn_nxt;
  logic [PCT_NW-1:0] st0_ln_r;
  logic [PCT_NW-1:0] st0_ln_nxt;
  logic [7:0]        st0_a_r;

  always_comb begin
    hsum    = {{2{in_hue_tenths[15]}}, in_hue_tenths} + 18'(HUE_BIAS);
    st0_hoff_nxt = hsum[16:0];
    sat_c   = (in_sat_tenths > 12'(PCT_MAX)) ? 10'(PCT_MAX) : in_sat_tenths[9:0];
    light_c = (in_light_tenths > 12'(PCT_MAX)) ? 10'(PCT_MAX) : in_light_tenths[9:0];
    st0_sn_nxt = {sat_c, {(FRAC_BITS-3){1'b0}}} + PCT_NW'(PCT_RND);
    st0_ln_nxt = {light_c, {(FRAC_BITS-3){1'b0}}} + PCT_NW'(PCT_RND);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st0_hoff_r <= st0_hoff_nxt;
      st0_sn_r   <= st0_sn_nxt;
      st0_ln_r   <= st0_ln_nxt;
      st0_a_r    <= in_alpha_byte;
    end
  end

  // Stage 1: hue modulo 3600 by restoring subtraction; reciprocal products.
  logic [16:0]              hv;
  logic [11:0]              st1_h_r;
  logic [PCT_NW+PCT_KW-1:0] st1_sp_r;
  logic [PCT_NW+PCT_KW-1:0] st1_lp_r;
  logic [PCT_NW-1:0]        st1_sn_r;
  logic [PCT_NW-1:0]        st1_ln_r;
  logic [7:0]               st1_a_r;

  always_comb begin
    hv = st0_hoff_r;
    for (int k = HUE_STEPS - 1; k >= 0; k--) begin
      if (hv >= 17'(HUE_FULL << k)) begin
        hv = hv - 17'(HUE_FULL << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      st1_h_r  <= hv[11:0];
      st1_sp_r <= (PCT_NW+PCT_KW)'(st0_sn_r) * (PCT_NW+PCT_KW)'(PCT_K);
      st1_lp_r <= (PCT_NW+PCT_KW)'(st0_ln_r) * (PCT_NW+PCT_KW)'(PCT_K);
      st1_sn_r <= st0_sn_r;
      st1_ln_r <= st0_ln_r;
      st1_a_r  <= st0_a_r;
    end
  end

  // Stage 2: correct the quotient estimates; find the sector and the ramp weight.
  logic [ONE_W-1:0]  sq_e;
  logic [ONE_W-1:0]  lq_e;
  logic [PCT_QW-1:0] s_rem;
  logic [PCT_QW-1:0] l_rem;
  logic [11:0]       t_h;
  logic [11:0]       ramp_dist;
  sector_t           sec_nxt;
  logic [ONE_W-1:0]  st2_s_r;
  logic [ONE_W-1:0]  st2_s_nxt;
  logic [ONE_W-1:0]  st2_l_r;
  logic [ONE_W-1:0]  st2_l_nxt;
  sector_t           st2_sec_r;
  logic [9:0]        st2_w_r;
  logic [9:0]        st2_w_nxt;
  logic [7:0]        st2_a_r;

  always_comb begin
    // The estimate is low by at most one; one compare of the remainder fixes it.
    sq_e  = st1_sp_r[PCT_SH +: ONE_W];
    lq_e  = st1_lp_r[PCT_SH +: ONE_W];
    s_rem = PCT_QW'(st1_sn_r) - PCT_QW'(sq_e) * PCT_QW'(PCT_DIV);
    l_rem = PCT_QW'(st1_ln_r) - PCT_QW'(lq_e) * PCT_QW'(PCT_DIV);
    st2_s_nxt = sq_e + ONE_W'(s_rem >= PCT_QW'(PCT_DIV));
    st2_l_nxt = lq_e + ONE_W'(l_rem >= PCT_QW'(PCT_DIV));

    if (st1_h_r >= 12'(SECTOR_SPAN * 5)) begin
      sec_nxt = SEC_MAG_RED;
    end else if (st1_h_r >= 12'(SECTOR_SPAN * 4)) begin
      sec_nxt = SEC_BLU_MAG;
    end else if (st1_h_r >= 12'(SECTOR_SPAN * 3)) begin
      sec_nxt = SEC_CYN_BLU;
    end else if (st1_h_r >= 12'(SECTOR_SPAN * 2)) begin
      sec_nxt = SEC_GRN_CYN;
    end else if (st1_h_r >= 12'(SECTOR_SPAN)) begin
      sec_nxt = SEC_YEL_GRN;
    end else begin
      sec_nxt = SEC_RED_YEL;
    end

    if (st1_h_r >= 12'(SECTOR_SPAN * 4)) begin
      t_h = st1_h_r - 12'(SECTOR_SPAN * 4);
    end else if (st1_h_r >= 12'(SECTOR_SPAN * 2)) begin
      t_h = st1_h_r - 12'(SECTOR_SPAN * 2);
    end else begin
      t_h = st1_h_r;
    end
    ramp_dist = (t_h >= 12'(SECTOR_SPAN)) ? (t_h - 12'(SECTOR_SPAN))
                                          : (12'(SECTOR_SPAN) - t_h);
    st2_w_nxt = 10'(12'(SECTOR_SPAN) - ramp_dist);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      st2_s_r   <= st2_s_nxt;
      st2_l_r   <= st2_l_nxt;
      st2_sec_r <= sec_nxt;
      st2_w_r   <= st2_w_nxt;
      st2_a_r   <= st1_a_r;
    end
  end

  // Stage 3: chroma product (1 - |2L - 1|) * S.
  logic [ONE_W:0]   twol;
  logic [ONE_W:0]   absd;
  logic [ONE_W-1:0] onem;
  logic [CP_W-1:0]  st3_cp_r;
  logic [ONE_W-1:0] st3_l_r;
  sector_t          st3_sec_r;
  logic [9:0]       st3_w_r;
  logic [7:0]       st3_a_r;

  always_comb begin
    twol = {st2_l_r, 1'b0};
    absd = (twol >= {1'b0, ONE}) ? (twol - {1'b0, ONE}) : ({1'b0, ONE} - twol);
    onem = ONE - absd[ONE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      st3_cp_r  <= CP_W'(onem) * CP_W'(st2_s_r);
      st3_l_r   <= st2_l_r;
      st3_sec_r <= st2_sec_r;
      st3_w_r   <= st2_w_r;
      st3_a_r   <= st2_a_r;
    end
  end

  // Stage 4: round the chroma back to the fixed-point format.
  logic [CP_W-1:0]  c_sum;
  logic [ONE_W-1:0] st4_c_r;
  logic [ONE_W-1:0] st4_l_r;
  sector_t          st4_sec_r;
  logic [9:0]       st4_w_r;
  logic [7:0]       st4_a_r;

  assign c_sum = st3_cp_r + CP_W'(HALF);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      st4_c_r   <= c_sum[FRAC_BITS +: ONE_W];
      st4_l_r   <= st3_l_r;
      st4_sec_r <= st3_sec_r;
      st4_w_r   <= st3_w_r;
      st4_a_r   <= st3_a_r;
    end
  end

  // Stage 5: weighted chroma for the intermediate value, and the offset M.
  logic [XP_W-1:0]  xprod;
  logic [ONE_W-1:0] c_half;
  logic [X_NW-1:0]  st5_xn_r;
  logic [ONE_W-1:0] st5_c_r;
  logic [ONE_W-1:0] st5_m_r;
  logic [ONE_W-1:0] st5_m_nxt;
  sector_t          st5_sec_r;
  logic [7:0]       st5_a_r;

  always_comb begin
    xprod     = XP_W'(st4_c_r) * XP_W'(st4_w_r) + XP_W'(X_RND);
    c_half    = st4_c_r >> 1;
    st5_m_nxt = (st4_l_r >= c_half) ? (st4_l_r - c_half) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      st5_xn_r  <= xprod[3 +: X_NW];
      st5_c_r   <= st4_c_r;
      st5_m_r   <= st5_m_nxt;
      st5_sec_r <= st4_sec_r;
      st5_a_r   <= st4_a_r;
    end
  end

  // Stage 6: reciprocal product for the division by the sector span.
  logic [X_NW+X_KW-1:0] st6_xp_r;
  logic [X_NW-1:0]      st6_xn_r;
  logic [ONE_W-1:0]     st6_c_r;
  logic [ONE_W-1:0]     st6_m_r;
  sector_t              st6_sec_r;
  logic [7:0]           st6_a_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      st6_xp_r  <= (X_NW+X_KW)'(st5_xn_r) * (X_NW+X_KW)'(X_K);
      st6_xn_r  <= st5_xn_r;
      st6_c_r   <= st5_c_r;
      st6_m_r   <= st5_m_r;
      st6_sec_r <= st5_sec_r;
      st6_a_r   <= st5_a_r;
    end
  end

  // Stage 7: correct the intermediate value estimate.
  logic [ONE_W-1:0] xq_e;
  logic [X_NW-1:0]  x_rem;
  logic [ONE_W-1:0] st7_x_r;
  logic [ONE_W-1:0] st7_x_nxt;
  logic [ONE_W-1:0] st7_c_r;
  logic [ONE_W-1:0] st7_m_r;
  sector_t          st7_sec_r;
  logic [7:0]       st7_a_r;

  always_comb begin
    xq_e      = st6_xp_r[X_SH +: ONE_W];
    x_rem     = st6_xn_r - X_NW'(xq_e) * X_NW'(X_DIV);
    st7_x_nxt = xq_e + ONE_W'(x_rem >= X_NW'(X_DIV));
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      st7_x_r   <= st7_x_nxt;
      st7_c_r   <= st6_c_r;
      st7_m_r   <= st6_m_r;
      st7_sec_r <= st6_sec_r;
      st7_a_r   <= st6_a_r;
    end
  end

  // Stage 8: place C and X by sector, add the offset, round each to a byte.
  logic [ONE_W-1:0] r_c;
  logic [ONE_W-1:0] g_c;
  logic [ONE_W-1:0] b_c;
  logic [31:0]      st8_word_r;
  logic [31:0]      st8_word_nxt;

  always_comb begin
    r_c = '0;
    g_c = '0;
    b_c = '0;
    unique case (st7_sec_r)
      SEC_RED_YEL: begin r_c = st7_c_r; g_c = st7_x_r; end
      SEC_YEL_GRN: begin r_c = st7_x_r; g_c = st7_c_r; end
      SEC_GRN_CYN: begin g_c = st7_c_r; b_c = st7_x_r; end
      SEC_CYN_BLU: begin g_c = st7_x_r; b_c = st7_c_r; end
      SEC_BLU_MAG: begin r_c = st7_x_r; b_c = st7_c_r; end
      default:     begin r_c = st7_c_r; b_c = st7_x_r; end
    endcase
    st8_word_nxt = {st7_a_r, to_byte(b_c, st7_m_r), to_byte(g_c, st7_m_r),
                    to_byte(r_c, st7_m_r)};
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      st8_word_r <= st8_word_nxt;
    end
  end

  assign out_rgba_word = st8_word_r;

endmodule
